// ===== src/modular_exponentiation_macros.svh =====
// assertion macros for the modular exponentiation block
// included by files that carry concurrent assertions; no other dependencies
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
`ifndef SYNTHESIS
`define MODEXP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("modexp assertion failed");
`define MODEXP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `MODEXP_ASSERT(lbl, clk, rstn, !(cond))
`else
`define MODEXP_ASSERT(lbl, clk, rstn, prop)
`define MODEXP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== src/modexp_pkg.sv =====
// shared types and constants for the modular exponentiation block
// used by modexp_mulmod and modular_exponentiation; no dependencies
package modexp_pkg;

  localparam int unsigned DefWidth = 32;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEXT,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_e;

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// ===== src/modexp_mulmod.sv =====
// bit-serial interleaved modular multiplier: (a * b) mod m, one bit of b per cycle
// depends on modexp_pkg; a zero modulus means products wrap at WIDTH bits
module modexp_mulmod #(
  parameter int unsigned WIDTH = modexp_pkg::DefWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  input  logic [WIDTH-1:0]     m_i,
  output logic [WIDTH-1:0]     result_o,
  output modexp_pkg::mm_stat_t stat_o
);
  import modexp_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [WIDTH-1:0]  a_q, b_q, m_q, acc_q, acc_d;
  logic [WIDTH+1:0]  sum, m1, m2, sub1, sub2;

  // acc < m and addend <= m, so the sum stays below 3m
  always_comb begin
    sum  = {1'b0, acc_q, 1'b0} + {2'b00, (b_q[WIDTH-1] ? a_q : {WIDTH{1'b0}})};
    m1   = {2'b00, m_q};
    m2   = {1'b0, m_q, 1'b0};
    sub1 = sum - m1;
    sub2 = sum - m2;
    if (m_q == '0) begin
      acc_d = sum[WIDTH-1:0];
    end else if (sum >= m2) begin
      acc_d = sub2[WIDTH-1:0];
    end else if (sum >= m1) begin
      acc_d = sub1[WIDTH-1:0];
    end else begin
      acc_d = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WIDTH - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[WIDTH-2:0], 1'b0};
    end
  end

  assign result_o = acc_q;
  assign stat_o   = '{busy: busy_q, done: done_q};

endmodule

// ===== src/modular_exponentiation.sv =====
// Modular exponentiation: power_residue = base_value ^ exponent mod modulus,
// right-to-left square-and-multiply on one shared bit-serial modular multiplier.
// Channels: cfg (valid/ready/data) writes the modulus, always ready; write it
// only while the block is idle. s_axis takes {exponent, base_value}, m_axis
// returns power_residue. A zero exponent gives 1, unreduced.
// Flow: one word at a time. Every multiplier pass is a start, WIDTH bit steps
// and a done strobe. A word costs one pass to
// reduce the base, one squaring pass per exponent bit below the highest set bit,
// and one multiply pass per set bit, then a finish step. The multiplier is the
// only arithmetic unit, and its passes set how long a word takes.
// s_axis_tready is high only while the sequencer is idle. The result sits in an
// output register, so a new word is taken while an earlier result waits; a
// finished result waits inside the block only when that register is still full.
// Reset: asynchronous, active low; modulus returns to 1, all channels go idle.
module modular_exponentiation #(
  parameter int unsigned WIDTH = modexp_pkg::DefWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration: modulus
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [WIDTH-1:0]                  cfg_data_i,
  // input words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: base_value, exponent (from lsb)
  input  logic [((2*WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: power_residue
  output logic [((WIDTH+7)/8)*8-1:0]        m_axis_tdata
);
  import modexp_pkg::*;

  `include "modular_exponentiation_macros.svh"

  localparam int unsigned OutW = ((WIDTH + 7) / 8) * 8;

  state_e           state_q, state_d;
  logic [WIDTH-1:0] modulus_q;
  logic [WIDTH-1:0] base_q, exp_q, acc_q, out_q;
  logic             out_valid_q;
  logic             in_acc, out_load;
  logic             mm_start;
  logic [WIDTH-1:0] op_a, op_b, mm_result;
  mm_stat_t         mm_stat;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  modexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .a_i      (op_a),
    .b_i      (op_b),
    .m_i      (modulus_q),
    .result_o (mm_result),
    .stat_o   (mm_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    mm_start      = 1'b0;
    op_a          = base_q;
    op_b          = base_q;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        // base reduction: horner over the base bits with addend 1
        op_a          = WIDTH'(1);
        op_b          = s_axis_tdata[WIDTH-1:0];
        if (s_axis_tvalid) begin
          mm_start = 1'b1;
          state_d  = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (exp_q == '0) begin
          state_d = ST_FINISH;
        end else if (exp_q[0]) begin
          op_a     = acc_q;
          mm_start = 1'b1;
          state_d  = ST_MUL;
        end else begin
          mm_start = 1'b1;
          state_d  = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_stat.done) state_d = ST_NEXT;
      end
      ST_SQR: begin
        if (mm_stat.done) state_d = ST_NEXT;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= WIDTH'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) modulus_q <= cfg_data_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      exp_q <= s_axis_tdata[2*WIDTH-1:WIDTH];
      acc_q <= WIDTH'(1);
    end
    if (mm_stat.done) begin
      case (state_q)
        ST_REDUCE: base_q <= mm_result;
        ST_MUL: begin
          acc_q    <= mm_result;
          exp_q[0] <= 1'b0;
        end
        ST_SQR: begin
          base_q <= mm_result;
          exp_q  <= exp_q >> 1;
        end
        default: ;
      endcase
    end
    if (out_load) out_q <= acc_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_q);

  `MODEXP_ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, mm_start && mm_stat.busy)
  `MODEXP_ASSERT(a_done_in_work_state, clk_i, rst_ni, mm_stat.done |-> (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR))
  `MODEXP_ASSERT(a_base_reduced, clk_i, rst_ni, (state_q == ST_SQR && modulus_q != '0) |-> (base_q < modulus_q))

endmodule
